FILE: src/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// Shared types and codes for the LIFO block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lba_pkg;

	localparam int ID_W     = 10;
	localparam int CNT_W    = 11;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 3;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ID_W-1:0]     blk_id_t;
	typedef logic [CNT_W-1:0]    count_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic REG_NUM_BLOCKS = 1'b0;

	localparam count_t NUM_BLOCKS_RST = 11'd1024;
	localparam count_t FREE_SAT       = 11'h7FF;

endpackage

`default_nettype wire

FILE: src/lba_ram.sv
// ----------------------------------------------------------------------------
// lba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lba_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/lifo_block_allocator.sv
// ----------------------------------------------------------------------------
// lifo_block_allocator
// Fixed-size block allocator with last-in first-out reuse of freed ids.
// ----------------------------------------------------------------------------
// Each request word allocates a block id or frees one. Fresh ids are issued
// from a counter starting at 0; freed ids go onto a stack held in a
// synchronous RAM and are reissued first. Every request returns one word with
// the granted id, a status and the free-block count. Sustained rate is one
// request per cycle while out_ready is high; a result passes the registered
// stack RAM read (stage 1), then the output register. num_blocks is written
// at APB address 0, by the user only while idle (not enforced by the block).
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_block_allocator #(
	parameter int POOL_CAP = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [lba_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output      logic [31:0]               prdata,
	output      logic                      pready,
	input  wire logic                      in_valid,
	output      logic                      in_ready,
	input  wire logic                      req_type,
	input  wire lba_pkg::blk_id_t          free_id,
	output      logic                      out_valid,
	input  wire logic                      out_ready,
	output      lba_pkg::blk_id_t          granted_id,
	output      lba_pkg::status_t          status,
	output      lba_pkg::count_t           blocks_free
);

	import lba_pkg::*;

	localparam int AW = $clog2(POOL_CAP);
	localparam int DW = $clog2(POOL_CAP + 1);
	localparam int CW = (DW > CNT_W) ? DW : CNT_W;

	logic            reg_idx;
	count_t          num_blocks_q;
	logic [DW-1:0]   depth_q;
	logic [CW-1:0]   fresh_q;

	logic            valid_s1;
	logic            pop_s1;
	blk_id_t         granted_s1;
	status_t         status_s1;
	count_t          free_s1;
	logic            s1_move;

	logic            out_valid_q;
	blk_id_t         granted_q;
	status_t         status_q;
	count_t          free_q;

	logic            in_fire;
	logic [CW-1:0]   pool;
	logic [CW-1:0]   fresh_left;
	logic [CW:0]     sum_pre;
	logic [CW:0]     sum_post;
	logic            do_pop;
	logic            do_fresh;
	logic            do_push;
	blk_id_t         grant_n;
	status_t         status_n;
	count_t          free_n;

	blk_id_t         ram_rdata;

	// APB register
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= NUM_BLOCKS_RST;
		end else if (psel && penable && pwrite && reg_idx == REG_NUM_BLOCKS) begin
			num_blocks_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_NUM_BLOCKS) begin
			prdata = {{(32-CNT_W){1'b0}}, num_blocks_q};
		end
	end

	// Request decode
	assign s1_move  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_move;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		pool = (CW'(num_blocks_q) > CW'(POOL_CAP)) ? CW'(POOL_CAP) : CW'(num_blocks_q);
		fresh_left = (fresh_q < pool) ? (pool - fresh_q) : '0;
		sum_pre = (CW+1)'(depth_q) + (CW+1)'(fresh_left);

		do_pop   = 1'b0;
		do_fresh = 1'b0;
		do_push  = 1'b0;
		grant_n  = '0;
		status_n = ST_OK;
		sum_post = sum_pre;

		if (req_type == REQ_ALLOC) begin
			if (depth_q != '0) begin
				do_pop   = 1'b1;
				sum_post = sum_pre - 1'b1;
			end else if (fresh_left != '0) begin
				do_fresh = 1'b1;
				grant_n  = fresh_q[ID_W-1:0];
				sum_post = sum_pre - 1'b1;
			end else begin
				status_n = ST_EMPTY;
			end
		end else begin
			if (sum_pre >= (CW+1)'(pool) || depth_q >= DW'(POOL_CAP)) begin
				status_n = ST_FULL;
			end else begin
				do_push  = 1'b1;
				sum_post = sum_pre + 1'b1;
			end
		end

		free_n = (sum_post > (CW+1)'(FREE_SAT)) ? FREE_SAT : sum_post[CNT_W-1:0];
	end

	// Stack memory
	lba_ram #(
		.WIDTH(ID_W),
		.DEPTH(POOL_CAP)
	) u_stack (
		.clk   (clk),
		.we    (in_fire && do_push),
		.waddr (depth_q[AW-1:0]),
		.wdata (free_id),
		.re    (in_fire && do_pop),
		.raddr (AW'(depth_q - 1'b1)),
		.rdata (ram_rdata)
	);

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			fresh_q <= '0;
		end else if (in_fire) begin
			if (do_pop) begin
				depth_q <= depth_q - 1'b1;
			end else if (do_push) begin
				depth_q <= depth_q + 1'b1;
			end
			if (do_fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
		end
	end

	// Stage 1: waits on the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pop_s1     <= do_pop;
			granted_s1 <= grant_n;
			status_s1  <= status_n;
			free_s1    <= free_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			granted_q <= pop_s1 ? ram_rdata : granted_s1;
			status_q  <= status_s1;
			free_q    <= free_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign granted_id  = granted_q;
	assign status      = status_q;
	assign blocks_free = free_q;

	// Checks
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(POOL_CAP))
		else $error("stack depth above pool capacity");

	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && do_push |=> depth_q == $past(depth_q) + 1'b1)
		else $error("push did not grow the stack");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pop_s1 |-> status_s1 == ST_OK)
		else $error("pop carried a failing status");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |-> !in_ready)
		else $error("request taken while stage 1 is stalled");

endmodule

`default_nettype wire
